@@ rtl/tlut_pkg.sv @@
// ----------------------------------------------------------------------------
// Taint label union table package
// Shared types and codes for the label table front end, queue and back end.
// ----------------------------------------------------------------------------
package tlut_pkg;

   typedef logic [5:0] label_type;

   // Operation codes as they arrive on the request port.
   typedef enum logic [1:0] {
      FUNC_CREATE   = 2'd0,
      FUNC_UNION    = 2'd1,
      FUNC_CONTAINS = 2'd2,
      FUNC_NONE     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   // Work classes handed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_DIRECT   = 2'd0,
      OP_CREATE   = 2'd1,
      OP_UNION    = 2'd2,
      OP_CONTAINS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_CONTAINS = 2'd1,
      ST_OR       = 2'd2,
      ST_SCAN     = 2'd3
   } state_type;

   typedef struct packed {
      op_type     op;
      label_type  label_a;
      label_type  label_b;
      label_type  label;
      status_type status;
   } cmd_type;

   localparam label_type OVERFLOW_LABEL = 6'd1;

endpackage

@@ rtl/taint_label_union_table_top.sv @@
// ----------------------------------------------------------------------------
// Taint label union table
// Maps taint labels to vectors of base taints; creates labels, forms unions
// and tests containment.
// ----------------------------------------------------------------------------
// Usage: drive req_func, req_label_a and req_label_b with start high; the word
// is taken at the clock edge where start is high and busy is low. busy stays
// high until the response has been produced, so one word is in flight at a
// time. The response appears for exactly one cycle with rsp_strobe high and
// must be captured then; the receiver cannot stall the block.
// After acceptance the word passes through the queue to the back end. Create,
// and unions or tests answered without the table, are answered when popped;
// contains first reads both vectors from the memory read ports; a union that
// searches the table ORs the two vectors and then reads one table entry per
// cycle through the memory read port, from label 0 up to the highest allocated
// label, answering at the first match or else allocating a new label.
// The next word can be taken in the cycle rsp_strobe is high.
// Reset clears the label counter to the overflow label; the table needs no
// clearing pass since entries above the counter are never used.
// ----------------------------------------------------------------------------
module taint_label_union_table_top #(
   parameter int LABEL_COUNT = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [5:0] req_label_a,
   input  logic [5:0] req_label_b,
   output logic       rsp_strobe,
   output logic [5:0] rsp_result_label,
   output logic       rsp_contains_flag,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_label_count
);

   localparam int IW = $clog2(LABEL_COUNT);

   tlut_pkg::cmd_type push_cmd;
   tlut_pkg::cmd_type head;
   logic              push;
   logic              pop;
   logic              empty;
   logic              done;
   logic [IW-1:0]     alloc_top;

   tlut_front #(
      .LABEL_COUNT(LABEL_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .req_label_a(req_label_a),
      .req_label_b(req_label_b),
      .alloc_top  (alloc_top),
      .done       (done),
      .push       (push),
      .cmd        (push_cmd)
   );

   tlut_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head    (head),
      .empty   (empty)
   );

   tlut_back #(
      .LABEL_COUNT(LABEL_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .done             (done),
      .alloc_top        (alloc_top),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_label (rsp_result_label),
      .rsp_contains_flag(rsp_contains_flag),
      .rsp_status       (rsp_status),
      .rsp_label_count  (rsp_label_count)
   );

endmodule

@@ rtl/tlut_front.sv @@
// ----------------------------------------------------------------------------
// Taint label union table front end
// Accepts request words, checks label validity, resolves the trivial cases
// and pushes a classified command into the queue.
// ----------------------------------------------------------------------------
module tlut_front #(
   parameter int LABEL_COUNT = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_func,
   input  logic [5:0]                     req_label_a,
   input  logic [5:0]                     req_label_b,
   input  logic [$clog2(LABEL_COUNT)-1:0] alloc_top,
   input  logic                           done,
   output logic                           push,
   output tlut_pkg::cmd_type              cmd
);

   localparam int IW = $clog2(LABEL_COUNT);
   localparam int CW = (IW > 6) ? IW : 6;

   logic busy_ff, busy_in;
   logic accept;
   logic bad_label;
   tlut_pkg::func_type func;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;
   assign push   = accept;
   assign func   = tlut_pkg::func_type'(req_func);

   // A label above the highest allocated one has no defined vector.
   assign bad_label = (CW'(req_label_a) > CW'(alloc_top)) ||
                      (CW'(req_label_b) > CW'(alloc_top));

   always_comb begin
      cmd.op      = tlut_pkg::OP_DIRECT;
      cmd.label_a = req_label_a;
      cmd.label_b = req_label_b;
      cmd.label   = '0;
      cmd.status  = tlut_pkg::STATUS_OK;
      unique case (func)
         tlut_pkg::FUNC_CREATE: begin
            cmd.op = tlut_pkg::OP_CREATE;
         end
         tlut_pkg::FUNC_UNION: begin
            if (bad_label) begin
               cmd.status = tlut_pkg::STATUS_INVALID;
            end else if (req_label_a == '0) begin
               cmd.label = req_label_b;
            end else if (req_label_b == '0 || req_label_a == req_label_b) begin
               cmd.label = req_label_a;
            end else begin
               cmd.op = tlut_pkg::OP_UNION;
            end
         end
         tlut_pkg::FUNC_CONTAINS: begin
            if (bad_label) begin
               cmd.status = tlut_pkg::STATUS_INVALID;
            end else begin
               cmd.op = tlut_pkg::OP_CONTAINS;
            end
         end
         default: begin
            cmd.op = tlut_pkg::OP_DIRECT;
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

@@ rtl/tlut_queue.sv @@
// ----------------------------------------------------------------------------
// Taint label union table command queue
// Two-entry queue of classified commands between front end and back end.
// ----------------------------------------------------------------------------
module tlut_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tlut_pkg::cmd_type push_cmd,
   input  logic              pop,
   output tlut_pkg::cmd_type head,
   output logic              empty
);

   localparam int DEPTH = 2;

   tlut_pkg::cmd_type entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && (count_ff != 2'(DEPTH));
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/tlut_back.sv @@
// ----------------------------------------------------------------------------
// Taint label union table back end
// Holds the label vector memory and the allocation counter, carries out
// create, union and contains commands and registers the response word.
// ----------------------------------------------------------------------------
module tlut_back #(
   parameter int LABEL_COUNT = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tlut_pkg::cmd_type              head,
   input  logic                           empty,
   output logic                           pop,
   output logic                           done,
   output logic [$clog2(LABEL_COUNT)-1:0] alloc_top,
   output logic                           rsp_strobe,
   output logic [5:0]                     rsp_result_label,
   output logic                           rsp_contains_flag,
   output logic [1:0]                     rsp_status,
   output logic [5:0]                     rsp_label_count
);

   localparam int IW = $clog2(LABEL_COUNT);
   localparam int VW = LABEL_COUNT;
   localparam logic [IW-1:0] LAST_MAX = IW'(LABEL_COUNT - 1);
   localparam logic [VW-1:0] OVF_VEC  = VW'(2);

   // Entries 0 and 1 are never written; their fixed vectors are muxed in.
   logic [VW-1:0] mem [LABEL_COUNT];

   tlut_pkg::state_type state_ff, state_in;
   logic [IW-1:0] last_ff, last_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [VW-1:0] vec_ff, vec_in;
   logic [IW-1:0] rd_addr_a, rd_addr_b, rd_addr_a_ff, rd_addr_b_ff;
   logic [VW-1:0] mem_a_ff, mem_b_ff;
   logic [VW-1:0] vec_a, vec_b;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic [IW-1:0] alloc_next;
   logic          full;
   logic          hit;

   logic                 emit;
   tlut_pkg::label_type  res_label;
   logic                 res_flag;
   tlut_pkg::status_type res_status;

   logic                 rsp_strobe_ff;
   tlut_pkg::label_type  rsp_label_ff;
   logic                 rsp_flag_ff;
   tlut_pkg::status_type rsp_status_ff;
   tlut_pkg::label_type  rsp_count_ff;

   assign vec_a = (rd_addr_a_ff == '0) ? '0 :
                  (rd_addr_a_ff == IW'(1)) ? OVF_VEC : mem_a_ff;
   assign vec_b = (rd_addr_b_ff == '0) ? '0 :
                  (rd_addr_b_ff == IW'(1)) ? OVF_VEC : mem_b_ff;

   assign alloc_next = last_ff + IW'(1);
   assign full       = (last_ff == LAST_MAX);
   assign hit        = (vec_a == vec_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlut_pkg::ST_IDLE: begin
            if (!empty) begin
               if (head.op == tlut_pkg::OP_CONTAINS) begin
                  state_in = tlut_pkg::ST_CONTAINS;
               end else if (head.op == tlut_pkg::OP_UNION) begin
                  state_in = tlut_pkg::ST_OR;
               end
            end
         end
         tlut_pkg::ST_CONTAINS: begin
            state_in = tlut_pkg::ST_IDLE;
         end
         tlut_pkg::ST_OR: begin
            state_in = tlut_pkg::ST_SCAN;
         end
         tlut_pkg::ST_SCAN: begin
            if (hit || scan_ff == last_ff) begin
               state_in = tlut_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlut_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop        = 1'b0;
      emit       = 1'b0;
      res_label  = '0;
      res_flag   = 1'b0;
      res_status = tlut_pkg::STATUS_OK;
      last_in    = last_ff;
      scan_in    = scan_ff;
      vec_in     = vec_ff;
      rd_addr_a  = '0;
      rd_addr_b  = '0;
      wr_en      = 1'b0;
      wr_addr    = alloc_next;
      wr_data    = vec_ff;
      unique case (state_ff)
         tlut_pkg::ST_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               rd_addr_a = IW'(head.label_a);
               rd_addr_b = IW'(head.label_b);
               case (head.op)
                  tlut_pkg::OP_DIRECT: begin
                     emit       = 1'b1;
                     res_label  = head.label;
                     res_status = head.status;
                  end
                  tlut_pkg::OP_CREATE: begin
                     emit = 1'b1;
                     if (full) begin
                        res_label  = tlut_pkg::OVERFLOW_LABEL;
                        res_status = tlut_pkg::STATUS_FULL;
                     end else begin
                        last_in   = alloc_next;
                        wr_en     = 1'b1;
                        wr_data   = VW'(1) << alloc_next;
                        res_label = 6'(alloc_next);
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         tlut_pkg::ST_CONTAINS: begin
            emit     = 1'b1;
            res_flag = ((vec_b & ~vec_a) == '0);
         end
         tlut_pkg::ST_OR: begin
            vec_in  = vec_a | vec_b;
            scan_in = '0;
         end
         tlut_pkg::ST_SCAN: begin
            if (hit) begin
               emit      = 1'b1;
               res_label = 6'(scan_ff);
            end else if (scan_ff == last_ff) begin
               // No label carries this vector yet, so allocate one if the table has room.
               emit = 1'b1;
               if (full) begin
                  res_label  = tlut_pkg::OVERFLOW_LABEL;
                  res_status = tlut_pkg::STATUS_FULL;
               end else begin
                  last_in   = alloc_next;
                  wr_en     = 1'b1;
                  res_label = 6'(alloc_next);
               end
            end else begin
               scan_in   = scan_ff + IW'(1);
               rd_addr_a = scan_ff + IW'(1);
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_a_ff     <= mem[rd_addr_a];
      mem_b_ff     <= mem[rd_addr_b];
      rd_addr_a_ff <= rd_addr_a;
      rd_addr_b_ff <= rd_addr_b;
   end

   always_ff @(posedge clock) begin
      vec_ff        <= vec_in;
      scan_ff       <= scan_in;
      rsp_label_ff  <= res_label;
      rsp_flag_ff   <= res_flag;
      rsp_status_ff <= res_status;
      rsp_count_ff  <= 6'(last_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tlut_pkg::ST_IDLE;
         last_ff       <= IW'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         rsp_strobe_ff <= emit;
      end
   end

   assign done              = emit;
   assign alloc_top         = last_ff;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_result_label  = rsp_label_ff;
   assign rsp_contains_flag = rsp_flag_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_label_count   = rsp_count_ff;

endmodule

@@ rtl/tlut_checker.sv @@
// ----------------------------------------------------------------------------
// Taint label union table checker
// Port-level checks on the request and response behaviour of the table.
// ----------------------------------------------------------------------------
module tlut_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [5:0] rsp_result_label,
   input logic       rsp_contains_flag,
   input logic [1:0] rsp_status
);

   // An accepted word keeps the block busy until its response.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // A response closes exactly the word that was in flight.
   a_rsp_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("response without a word in flight");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == tlut_pkg::STATUS_INVALID |->
         rsp_result_label == 6'd0 && !rsp_contains_flag)
      else $error("invalid status with non-zero result");

   a_full_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == tlut_pkg::STATUS_FULL |->
         rsp_result_label == tlut_pkg::OVERFLOW_LABEL)
      else $error("full status without the overflow label");

endmodule

bind taint_label_union_table_top tlut_checker u_tlut_checker (.*);
